// ===== rtl/core/button_click_classifier_top_defines.svh =====
// Assertion macros for the button click classifier RTL.
// Needs signals clk and rst_n in the scope that uses the macros.
`ifndef BUTTON_CLICK_CLASSIFIER_TOP_DEFINES_SVH
`define BUTTON_CLICK_CLASSIFIER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BCC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bcc assertion failed");

// Next-cycle implication, checked outside reset.
`define BCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bcc assertion failed");

`endif

// ===== rtl/core/bcc_pkg.sv =====
// Shared types and constants of the button click classifier.
// No dependencies; imported by the interfaces and all modules.
package bcc_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned MS_CFG_W  = 16;
  localparam int unsigned CFG_IDX_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_LOW   = 8'd0,
    CFG_DEBOUNCE     = 8'd1,
    CFG_DBL_WINDOW   = 8'd2,
    CFG_LONG_PRESS   = 8'd3
  } cfg_idx_t;

  localparam logic                ACTIVE_LOW_RST = 1'b1;
  localparam logic [MS_CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [MS_CFG_W-1:0] DBL_WINDOW_RST = 16'd300;
  localparam logic [MS_CFG_W-1:0] LONG_PRESS_RST = 16'd1000;

  typedef struct packed {
    logic                active_low;
    logic [MS_CFG_W-1:0] debounce_ms;
    logic [MS_CFG_W-1:0] double_click_window_ms;
    logic [MS_CFG_W-1:0] long_press_ms;
  } cfg_t;

  typedef struct packed {
    logic              press_edge;
    logic              release_edge;
    logic              single_click;
    logic              double_click;
    logic              long_press;
    logic              is_held;
    logic [TIME_W-1:0] held_ms;
  } result_t;

endpackage

// ===== rtl/core/bcc_in_if.sv =====
// Sample channel of the button click classifier: valid/ready plus one sample.
// Depends on bcc_pkg.
interface bcc_in_if import bcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              button_level;
  logic [TIME_W-1:0] time_ms;

  modport source (output valid, button_level, time_ms, input ready);
  modport sink   (input valid, button_level, time_ms, output ready);
endinterface

// ===== rtl/core/bcc_out_if.sv =====
// Result channel of the button click classifier: valid/ready plus event flags.
// Depends on bcc_pkg.
interface bcc_out_if import bcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              press_edge;
  logic              release_edge;
  logic              single_click;
  logic              double_click;
  logic              long_press;
  logic              is_held;
  logic [TIME_W-1:0] held_ms;

  modport source (output valid, press_edge, release_edge, single_click, double_click,
                  long_press, is_held, held_ms, input ready);
  modport sink   (input valid, press_edge, release_edge, single_click, double_click,
                  long_press, is_held, held_ms, output ready);
endinterface

// ===== rtl/core/bcc_cfg_if.sv =====
// Configuration write channel: valid/ready, register index and write data.
// Depends on bcc_pkg.
interface bcc_cfg_if import bcc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [MS_CFG_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/button_click_classifier_top.sv =====
// Top level of the button click classifier: input stage, classifier, result stage.
// Depends on bcc_pkg, the channel interfaces, bcc_cfg_regs and bcc_classify.
//
// Usage:
//   in_ch   - one raw sample per item: button_level and a millisecond time_ms
//             (wraps modulo 2^32). Valid/ready; accepted when both are high.
//   out_ch  - exactly one result item per sample: press/release edges,
//             single/double click, long press, is_held and held_ms.
//   cfg_ch  - register writes (index, data); always ready. Write only while
//             the block is idle: 0 active_low, 1 debounce_ms,
//             2 double_click_window_ms, 3 long_press_ms. Other indexes drop.
// Path: an accepted sample passes the input register, one pass of classify logic
//   and the result register before its result shows on out_ch.
// Throughput: one item per cycle while out_ch is ready; the classifier state loop
//   is one register deep: the next sample uses this one's state without stalls.
// Stall: while out_ch is stalled the result register holds, one more sample
//   may wait in the input register, then in_ch.ready drops.
// Reset (rst_n low, synchronous): valid, state and config registers return to
//   their reset values, the debounced level to the idle level and both stages empty.
`include "button_click_classifier_top_defines.svh"
module button_click_classifier_top import bcc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  bcc_in_if.sink     in_ch,
  bcc_out_if.source  out_ch,
  bcc_cfg_if.sink    cfg_ch
);

  // Input register stage.
  logic              in_valid_r;
  logic              in_level_r;
  logic [TIME_W-1:0] in_time_r;

  // Result register stage.
  logic              out_valid_r;
  result_t           out_res_r;

  cfg_t              cfg;
  result_t           res;
  logic              advance;

  // Advance the held sample when the result register is empty or drains now.
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  bcc_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  bcc_classify u_classify (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (advance),
    .level      (in_level_r),
    .now        (in_time_r),
    .cfg        (cfg),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  // Capture payload only on a handshake.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_level_r <= in_ch.button_level;
      in_time_r  <= in_ch.time_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.press_edge   = out_res_r.press_edge;
  assign out_ch.release_edge = out_res_r.release_edge;
  assign out_ch.single_click = out_res_r.single_click;
  assign out_ch.double_click = out_res_r.double_click;
  assign out_ch.long_press   = out_res_r.long_press;
  assign out_ch.is_held      = out_res_r.is_held;
  assign out_ch.held_ms      = out_res_r.held_ms;

  // A waiting sample must never be overwritten while the result side stalls.
  `BCC_ASSERT_NEXT(a_in_hold, in_valid_r && !advance, in_valid_r)
  // held_ms is nonzero only while the button reads as pressed.
  `BCC_ASSERT_NOW(a_held_ms_idle, out_valid_r && (out_res_r.held_ms != '0), out_res_r.is_held)
  // A press and a release never come from the same sample.
  `BCC_ASSERT_NOW(a_edge_excl, out_valid_r, !(out_res_r.press_edge && out_res_r.release_edge))

endmodule

// ===== rtl/core/bcc_cfg_regs.sv =====
// Configuration register file of the button click classifier.
// Depends on bcc_pkg and bcc_cfg_if.
module bcc_cfg_regs import bcc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  bcc_cfg_if.sink   cfg_ch,
  output cfg_t      cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_ACTIVE_LOW: cfg_nxt.active_low             = cfg_ch.data[0];
        CFG_DEBOUNCE:   cfg_nxt.debounce_ms            = cfg_ch.data;
        CFG_DBL_WINDOW: cfg_nxt.double_click_window_ms = cfg_ch.data;
        CFG_LONG_PRESS: cfg_nxt.long_press_ms          = cfg_ch.data;
        default:        cfg_nxt = cfg_r;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.active_low             <= ACTIVE_LOW_RST;
      cfg_r.debounce_ms            <= DEBOUNCE_RST;
      cfg_r.double_click_window_ms <= DBL_WINDOW_RST;
      cfg_r.long_press_ms          <= LONG_PRESS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/core/bcc_classify.sv =====
// Debounce and click classification: state registers plus next-state logic.
// Depends on bcc_pkg and button_click_classifier_top_defines.svh.
`include "button_click_classifier_top_defines.svh"
module bcc_classify import bcc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  logic              level,
  input  logic [TIME_W-1:0] now,
  input  cfg_t              cfg,
  output result_t           res
);

  logic              stable_r,       stable_nxt;
  logic [TIME_W-1:0] last_change_r,  last_change_nxt;
  logic [TIME_W-1:0] press_start_r,  press_start_nxt;
  logic [TIME_W-1:0] last_release_r, last_release_nxt;
  logic              awaiting_r,     awaiting_nxt;
  logic              long_done_r,    long_done_nxt;

  logic [TIME_W-1:0] d_change;
  logic [TIME_W-1:0] d_press;
  logic [TIME_W-1:0] d_rel;
  logic [TIME_W-1:0] hold_diff;
  logic [TIME_W-1:0] rel_diff;
  logic [TIME_W-1:0] debounce_w;
  logic [TIME_W-1:0] window_w;
  logic [TIME_W-1:0] long_w;
  logic              change;
  logic              was_pressed;
  logic              now_pressed;
  logic              held;

  assign d_change   = now - last_change_r;
  assign d_press    = now - press_start_r;
  assign d_rel      = now - last_release_r;
  assign debounce_w = {{(TIME_W-MS_CFG_W){1'b0}}, cfg.debounce_ms};
  assign window_w   = {{(TIME_W-MS_CFG_W){1'b0}}, cfg.double_click_window_ms};
  assign long_w     = {{(TIME_W-MS_CFG_W){1'b0}}, cfg.long_press_ms};

  // Pressed when the level differs from the idle level (idle = active_low).
  assign was_pressed = stable_r ^ cfg.active_low;
  assign now_pressed = level ^ cfg.active_low;
  assign change      = (level != stable_r) && (d_change > debounce_w);

  always_comb begin
    stable_nxt       = stable_r;
    last_change_nxt  = last_change_r;
    press_start_nxt  = press_start_r;
    last_release_nxt = last_release_r;
    awaiting_nxt     = awaiting_r;
    long_done_nxt    = long_done_r;
    hold_diff        = d_press;
    rel_diff         = d_rel;
    res              = '0;

    if (change) begin
      last_change_nxt = now;
      stable_nxt      = level;
      priority if (now_pressed && !was_pressed) begin
        res.press_edge  = 1'b1;
        press_start_nxt = now;
        long_done_nxt   = 1'b0;
        hold_diff       = '0;
      end else if (!now_pressed && was_pressed) begin
        res.release_edge = 1'b1;
        priority if (long_done_r) begin
          // release after a reported long press is not a click
        end else if (d_press >= long_w) begin
          res.long_press = 1'b1;
          long_done_nxt  = 1'b1;
          awaiting_nxt   = 1'b0;
        end else begin
          if (awaiting_r && (d_rel <= window_w)) begin
            res.double_click = 1'b1;
            awaiting_nxt     = 1'b0;
          end else begin
            awaiting_nxt = 1'b1;
          end
          last_release_nxt = now;
          rel_diff         = '0;
        end
      end
    end

    held        = stable_nxt ^ cfg.active_low;
    res.is_held = held;

    if (held && !long_done_nxt && (hold_diff >= long_w)) begin
      res.long_press = 1'b1;
      long_done_nxt  = 1'b1;
      awaiting_nxt   = 1'b0;
    end

    if (awaiting_nxt && (rel_diff > window_w)) begin
      res.single_click = 1'b1;
      awaiting_nxt     = 1'b0;
    end

    res.held_ms = held ? hold_diff : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_r       <= ACTIVE_LOW_RST;
      last_change_r  <= '0;
      press_start_r  <= '0;
      last_release_r <= '0;
      awaiting_r     <= 1'b0;
      long_done_r    <= 1'b0;
    end else if (item_valid) begin
      stable_r       <= stable_nxt;
      last_change_r  <= last_change_nxt;
      press_start_r  <= press_start_nxt;
      last_release_r <= last_release_nxt;
      awaiting_r     <= awaiting_nxt;
      long_done_r    <= long_done_nxt;
    end
  end

  // Press without a long press clears long_done_r; zero threshold: long at once.
  `BCC_ASSERT_NEXT(a_press_clears_long, item_valid && res.press_edge && !res.long_press, !long_done_r)
  `BCC_ASSERT_NOW(a_one_click_kind, item_valid, !(res.single_click && res.double_click))
  `BCC_ASSERT_NEXT(a_long_sets_done, item_valid && res.long_press, long_done_r && !awaiting_r)

endmodule
